### hdl/bbpa_pkg.sv
// Shared constants of the bitmap block pool allocator: default sizes,
// register indexes and result status codes.
// No dependencies.
`default_nettype none

package bbpa_pkg;

	// default pool geometry
	localparam int MAX_UNITS_DEF = 1024;
	localparam int WORD_BITS_DEF = 32;

	// field widths
	localparam int ADDR_W   = 32;
	localparam int SIZE_W   = 16;
	localparam int COUNT_W  = 11;
	localparam int INDEX_W  = 10;
	localparam int STATUS_W = 2;
	localparam int CFG_IDX_W = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_POOL_BYTES   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_UNIT_SIZE    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_UNIT_COUNT   = 2'd3;

	// register reset values
	localparam logic [ADDR_W-1:0]  BASE_ADDRESS_RST = 32'd0;
	localparam logic [ADDR_W-1:0]  POOL_BYTES_RST   = 32'd1024;
	localparam logic [SIZE_W-1:0]  UNIT_SIZE_RST    = 16'd1;
	localparam logic [COUNT_W-1:0] UNIT_COUNT_RST   = 11'd1024;

	// opcodes
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	// result status codes
	localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_EXHAUSTED = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_OUTSIDE   = 2'd2;
	localparam logic [STATUS_W-1:0] STATUS_BEYOND    = 2'd3;

endpackage

`default_nettype wire

### hdl/bitmap_block_pool_allocator_core.sv
// Bitmap block pool allocator: free bitmap memory, word scan for allocate,
// serial divider for the free address to unit mapping.
// Depends on bbpa_pkg.
//
// Channel  | Direction | Handshake            | Payload
// ---------+-----------+----------------------+----------------------------------
// request  | in        | start, busy          | opcode, free_address
// result   | out       | done (one-cycle)     | status, unit_index, unit_address
// config   | in        | cfg_valid, cfg_ready | cfg_index, cfg_data
//
// Allocate reads the bitmap one word per cycle, the check of a word overlapping the next
// read, up to 32 words with the default geometry; a found unit then passes ST_MUL and
// ST_ADD before done. Exhausted status ends the scan when every word read is empty, when
// the first non-empty word holds only bits past the count, or before any read with a zero count.
// Free runs 32 steps of the radix-2 divider (offset / unit size) and then a
// read-modify-write of the bitmap word; it ends after the divider when the index is beyond
// the count, and straight from idle when the address is outside the pool. WORD_BITS must be a power of two.
// The bitmap needs no clearing pass: per-word valid bits, cleared by reset,
// make a never-written word read as all free. cfg_ready is always high.
// done is a one-cycle strobe; the receiver cannot stall it.
`default_nettype none

module bitmap_block_pool_allocator_core #(
	parameter int MAX_UNITS = bbpa_pkg::MAX_UNITS_DEF,
	parameter int WORD_BITS = bbpa_pkg::WORD_BITS_DEF
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	// request
	input  wire                                 start,
	output logic                                busy,
	input  wire                                 opcode,
	input  wire  [bbpa_pkg::ADDR_W-1:0]         free_address,
	// result
	output logic                                done,
	output logic [bbpa_pkg::STATUS_W-1:0]       status,
	output logic [bbpa_pkg::INDEX_W-1:0]        unit_index,
	output logic [bbpa_pkg::ADDR_W-1:0]         unit_address,
	// configuration
	input  wire                                 cfg_valid,
	output logic                                cfg_ready,
	input  wire  [bbpa_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire  [bbpa_pkg::ADDR_W-1:0]         cfg_data
);

	localparam int MAP_WORDS = (MAX_UNITS + WORD_BITS - 1) / WORD_BITS;
	localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int BW        = $clog2(WORD_BITS);
	localparam int IDX_W     = $clog2(MAX_UNITS);
	localparam int UW        = $clog2(MAX_UNITS + WORD_BITS + 1);
	localparam int CW        = (UW > bbpa_pkg::COUNT_W) ? UW : bbpa_pkg::COUNT_W;
	localparam int DIV_STEPS = bbpa_pkg::ADDR_W;
	localparam int DIV_CW    = $clog2(DIV_STEPS);

	// sequencer states
	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_SCAN    = 3'd1;
	localparam logic [2:0] ST_MUL     = 3'd2;
	localparam logic [2:0] ST_ADD     = 3'd3;
	localparam logic [2:0] ST_DIV1    = 3'd4;
	localparam logic [2:0] ST_FREE_RD = 3'd6;
	localparam logic [2:0] ST_FREE_WR = 3'd7;

	// configuration registers
	logic [bbpa_pkg::ADDR_W-1:0]  base_address_q;
	logic [bbpa_pkg::ADDR_W-1:0]  pool_bytes_q;
	logic [bbpa_pkg::SIZE_W-1:0]  unit_size_q;
	logic [bbpa_pkg::COUNT_W-1:0] unit_count_q;

	// sequencer and datapath registers
	logic [2:0]                   state_q;
	logic [AW-1:0]                rd_w_q;
	logic [CW-1:0]                rd_base_q;
	logic                         issued_s1;
	logic [AW-1:0]                chk_w_s1;
	logic [CW-1:0]                chk_base_s1;
	logic [IDX_W-1:0]             idx_q;
	logic [bbpa_pkg::ADDR_W-1:0]  prod_s1;
	logic [bbpa_pkg::ADDR_W-1:0]  dvd_q;
	logic [bbpa_pkg::SIZE_W-1:0]  rem_q;
	logic [bbpa_pkg::SIZE_W-1:0]  dvs_q;
	logic [DIV_CW-1:0]            div_cnt_q;
	logic                         done_q;
	logic [bbpa_pkg::STATUS_W-1:0] status_q;
	logic [bbpa_pkg::INDEX_W-1:0] index_q;
	logic [bbpa_pkg::ADDR_W-1:0]  address_q;

	// bitmap memory
	logic [WORD_BITS-1:0]         map_mem [MAP_WORDS];
	logic [MAP_WORDS-1:0]         word_vld_q;
	logic [WORD_BITS-1:0]         rd_data_s1;
	logic                         rd_vld_s1;
	logic                         mem_rd;
	logic [AW-1:0]                mem_raddr;
	logic                         mem_wr;
	logic [AW-1:0]                mem_waddr;
	logic [WORD_BITS-1:0]         mem_wdata;

	// combinational
	logic [bbpa_pkg::SIZE_W-1:0]  eff_size;
	logic [CW-1:0]                cnt_ext;
	logic [CW-1:0]                cnt_eff;
	logic [WORD_BITS-1:0]         word_eff;
	logic [BW-1:0]                low_bit;
	logic [CW-1:0]                idx_alloc;
	logic                         found_hit;
	logic                         issue;
	logic                         accept;
	logic                         addr_low;
	logic [bbpa_pkg::ADDR_W:0]    pool_end;
	logic                         addr_high;
	logic [bbpa_pkg::SIZE_W:0]    rem_sh;
	logic                         div_ge;
	logic [bbpa_pkg::SIZE_W-1:0]  rem_next;
	logic [bbpa_pkg::ADDR_W-1:0]  dvd_next;
	logic                         div_last;

	assign cfg_ready    = 1'b1;
	assign busy         = (state_q != ST_IDLE);
	assign done         = done_q;
	assign status       = status_q;
	assign unit_index   = index_q;
	assign unit_address = address_q;
	assign accept       = start && !busy;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_address_q <= bbpa_pkg::BASE_ADDRESS_RST;
			pool_bytes_q   <= bbpa_pkg::POOL_BYTES_RST;
			unit_size_q    <= bbpa_pkg::UNIT_SIZE_RST;
			unit_count_q   <= bbpa_pkg::UNIT_COUNT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				bbpa_pkg::REG_BASE_ADDRESS: base_address_q <= cfg_data;
				bbpa_pkg::REG_POOL_BYTES:   pool_bytes_q   <= cfg_data;
				bbpa_pkg::REG_UNIT_SIZE:    unit_size_q    <= cfg_data[bbpa_pkg::SIZE_W-1:0];
				bbpa_pkg::REG_UNIT_COUNT:   unit_count_q   <= cfg_data[bbpa_pkg::COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// effective unit size and count (zero size acts as one, count clamps)
	assign eff_size = (unit_size_q == '0) ? bbpa_pkg::SIZE_W'(1) : unit_size_q;
	assign cnt_ext  = CW'(unit_count_q);
	assign cnt_eff  = (cnt_ext > CW'(MAX_UNITS)) ? CW'(MAX_UNITS) : cnt_ext;

	// free address range check, end taken without wrap
	assign addr_low  = free_address < base_address_q;
	assign pool_end  = {1'b0, base_address_q} + {1'b0, pool_bytes_q};
	assign addr_high = {1'b0, free_address} >= pool_end;

	// bitmap word as read; a never-written word is all free
	assign word_eff = rd_vld_s1 ? rd_data_s1 : '1;

	// lowest set bit of the checked word
	always_comb begin
		low_bit = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (word_eff[i]) low_bit = BW'(i);
		end
	end

	assign idx_alloc = chk_base_s1 + CW'(low_bit);
	assign found_hit = (state_q == ST_SCAN) && issued_s1 && (word_eff != '0);
	assign issue     = (state_q == ST_SCAN) && (rd_base_q < cnt_eff) && !found_hit;

	// one restoring divider step
	assign rem_sh   = {rem_q, dvd_q[bbpa_pkg::ADDR_W-1]};
	assign div_ge   = rem_sh >= {1'b0, dvs_q};
	assign rem_next = div_ge ? bbpa_pkg::SIZE_W'(rem_sh - {1'b0, dvs_q})
	                         : rem_sh[bbpa_pkg::SIZE_W-1:0];
	assign dvd_next = {dvd_q[bbpa_pkg::ADDR_W-2:0], div_ge};
	assign div_last = (div_cnt_q == DIV_CW'(DIV_STEPS - 1));

	// memory port control
	always_comb begin
		mem_rd    = issue || (state_q == ST_FREE_RD);
		mem_raddr = (state_q == ST_SCAN) ? rd_w_q : dvd_q[AW-1:0];
		mem_wr    = 1'b0;
		mem_waddr = chk_w_s1;
		mem_wdata = word_eff & ~(WORD_BITS'(1) << low_bit);
		if (found_hit && (idx_alloc < cnt_eff)) begin
			mem_wr = 1'b1;
		end else if (state_q == ST_FREE_WR) begin
			mem_wr    = 1'b1;
			mem_waddr = dvd_q[AW-1:0];
			mem_wdata = word_eff | (WORD_BITS'(1) << rem_q[BW-1:0]);
		end
	end

	// bitmap RAM, one read and one write port, registered read
	always_ff @(posedge clk) begin
		if (mem_wr) map_mem[mem_waddr] <= mem_wdata;
		if (mem_rd) begin
			rd_data_s1 <= map_mem[mem_raddr];
			rd_vld_s1  <= word_vld_q[mem_raddr];
		end
	end

	// per-word written marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_vld_q <= '0;
		end else if (mem_wr) begin
			word_vld_q[mem_waddr] <= 1'b1;
		end
	end

	// request sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rd_w_q      <= '0;
			rd_base_q   <= '0;
			issued_s1   <= 1'b0;
			chk_w_s1    <= '0;
			chk_base_s1 <= '0;
			idx_q       <= '0;
			prod_s1     <= '0;
			dvd_q       <= '0;
			rem_q       <= '0;
			dvs_q       <= '0;
			div_cnt_q   <= '0;
			done_q      <= 1'b0;
			status_q    <= bbpa_pkg::STATUS_OK;
			index_q     <= '0;
			address_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (opcode == bbpa_pkg::OP_ALLOC) begin
							rd_w_q    <= '0;
							rd_base_q <= '0;
							issued_s1 <= 1'b0;
							state_q   <= ST_SCAN;
						end else if (addr_low || addr_high) begin
							done_q    <= 1'b1;
							status_q  <= bbpa_pkg::STATUS_OUTSIDE;
							index_q   <= '0;
							address_q <= '0;
						end else begin
							dvd_q     <= free_address - base_address_q;
							rem_q     <= '0;
							dvs_q     <= eff_size;
							div_cnt_q <= '0;
							state_q   <= ST_DIV1;
						end
					end
				end
				ST_SCAN: begin
					// read one word a cycle, check the word read the cycle before
					issued_s1   <= issue;
					chk_w_s1    <= rd_w_q;
					chk_base_s1 <= rd_base_q;
					if (issue) begin
						rd_w_q    <= rd_w_q + AW'(1);
						rd_base_q <= rd_base_q + CW'(WORD_BITS);
					end
					if (found_hit) begin
						if (idx_alloc < cnt_eff) begin
							idx_q   <= IDX_W'(idx_alloc);
							state_q <= ST_MUL;
						end else begin
							done_q    <= 1'b1;
							status_q  <= bbpa_pkg::STATUS_EXHAUSTED;
							index_q   <= '0;
							address_q <= '0;
							state_q   <= ST_IDLE;
						end
					end else if (!issued_s1 && (rd_base_q >= cnt_eff)) begin
						done_q    <= 1'b1;
						status_q  <= bbpa_pkg::STATUS_EXHAUSTED;
						index_q   <= '0;
						address_q <= '0;
						state_q   <= ST_IDLE;
					end
				end
				ST_MUL: begin
					prod_s1 <= 32'(eff_size) * 32'(idx_q);
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					done_q    <= 1'b1;
					status_q  <= bbpa_pkg::STATUS_OK;
					index_q   <= bbpa_pkg::INDEX_W'(idx_q);
					address_q <= base_address_q + prod_s1;
					state_q   <= ST_IDLE;
				end
				ST_DIV1: begin
					// offset / unit size, one quotient bit a cycle
					if (!div_last) begin
						dvd_q     <= dvd_next;
						rem_q     <= rem_next;
						div_cnt_q <= div_cnt_q + DIV_CW'(1);
					end else if (dvd_next >= 32'(cnt_eff)) begin
						done_q    <= 1'b1;
						status_q  <= bbpa_pkg::STATUS_BEYOND;
						index_q   <= '0;
						address_q <= '0;
						state_q   <= ST_IDLE;
					end else begin
						// word is the index shifted down, bit is its low part
						idx_q     <= IDX_W'(dvd_next);
						dvd_q     <= dvd_next >> BW;
						rem_q     <= bbpa_pkg::SIZE_W'(dvd_next[BW-1:0]);
						div_cnt_q <= '0;
						state_q   <= ST_FREE_RD;
					end
				end
				ST_FREE_RD: begin
					state_q <= ST_FREE_WR;
				end
				ST_FREE_WR: begin
					done_q    <= 1'b1;
					status_q  <= bbpa_pkg::STATUS_OK;
					index_q   <= bbpa_pkg::INDEX_W'(idx_q);
					address_q <= '0;
					state_q   <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	// a failed request reports zero index and address
	ast_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status != bbpa_pkg::STATUS_OK) |-> (unit_index == '0) && (unit_address == '0))
		else $error("failed request with nonzero index or address");

	// result strobe only once the sequencer is back to idle
	ast_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// an accepted request either starts work or answers at once
	ast_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy || done)
		else $error("accepted request dropped");

	// bitmap writes only from the allocate scan or the free write-back
	ast_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		mem_wr |-> (state_q == ST_SCAN) || (state_q == ST_FREE_WR))
		else $error("bitmap write outside scan or free write-back");
`endif

endmodule

`default_nettype wire
